// ===== hw/rtl/greedy_line_breaker_defines.svh =====
// ----------------------------------------------------------------------------
// Greedy line breaker assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_LINE_BREAKER_DEFINES_SVH
`define GREEDY_LINE_BREAKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("greedy line breaker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("greedy line breaker: next-cycle check failed");

`endif

// ===== hw/rtl/glb_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy line breaker package
// Word types, character class codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package glb_pkg;

  typedef logic [1:0] char_class_t;

  localparam char_class_t CLS_OTHER   = 2'd0;
  localparam char_class_t CLS_SPACE   = 2'd1;
  localparam char_class_t CLS_NEWLINE = 2'd2;
  localparam char_class_t CLS_END     = 2'd3;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_MAX_WIDTH       = 2'd0;
  localparam cfg_index_t CFG_MAX_LINES       = 2'd1;
  localparam cfg_index_t CFG_MISSING_ADVANCE = 2'd2;

  localparam int CFG_DATA_BITS = 16;

  localparam logic [15:0] MAX_WIDTH_RST       = 16'd65535;
  localparam logic [8:0]  MAX_LINES_RST       = 9'd256;
  localparam logic [11:0] MISSING_ADVANCE_RST = 12'd8;

  typedef struct packed {
    char_class_t char_class;
    logic [2:0]  byte_length;
    logic        glyph_present;
    logic [11:0] glyph_advance;
  } in_word_t;

  typedef struct packed {
    logic        is_final;
    logic [7:0]  line_index;
    logic [15:0] break_offset;
    logic [8:0]  line_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0] max_width;
    logic [8:0]  max_lines;
    logic [11:0] missing_advance;
  } cfg_t;

endpackage

// ===== hw/rtl/glb_core.sv =====
// ----------------------------------------------------------------------------
// Greedy line breaker core
// Line state registers and the per-word break decision.
// ----------------------------------------------------------------------------
`include "greedy_line_breaker_defines.svh"

module glb_core #(
  parameter int MAX_LINES   = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  glb_pkg::in_word_t item,
  input  glb_pkg::cfg_t     cfg,
  output logic              res_vld,
  output glb_pkg::out_word_t res
);
  import glb_pkg::*;

  localparam int          LINE_CAP   = (MAX_LINES < 256) ? MAX_LINES : 256;
  localparam logic [8:0]  LINE_CAP_W = LINE_CAP[8:0];

  logic [7:0]             lines_done_r, lines_done_nxt;
  logic [OFFSET_BITS-1:0] line_begin_r, line_begin_nxt;
  logic                   space_valid_r, space_valid_nxt;
  logic [OFFSET_BITS-1:0] space_after_r, space_after_nxt;
  logic [17:0]            space_pen_r, space_pen_nxt;
  logic [17:0]            pen_x_r, pen_x_nxt;
  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic                   halted_r, halted_nxt;

  logic [OFFSET_BITS-1:0]    next_pos;
  logic [8:0]                lines_inc;
  logic [8:0]                lim_floor;
  logic [8:0]                lim;
  logic                      at_limit;
  logic [11:0]               adv;
  logic [18:0]               pen_sum;
  logic [17:0]               pen_sat;
  logic                      is_space;
  logic                      sp_valid_e;
  logic [OFFSET_BITS-1:0]    sp_after_e;
  logic [17:0]               sp_pen_e;
  logic                      over;
  logic                      use_space;
  logic [17:0]               pen_rem;
  logic                      brk;
  logic [OFFSET_BITS+15:0]   begin_ext;

  always_comb begin
    next_pos  = byte_pos_r + OFFSET_BITS'(item.byte_length);
    lines_inc = {1'b0, lines_done_r} + 9'd1;
    lim_floor = (cfg.max_lines == 9'd0) ? 9'd1 : cfg.max_lines;
    lim       = (lim_floor > LINE_CAP_W) ? LINE_CAP_W : lim_floor;
    at_limit  = lines_inc >= lim;

    adv     = item.glyph_present ? item.glyph_advance : cfg.missing_advance;
    pen_sum = {1'b0, pen_x_r} + {7'd0, adv};
    pen_sat = pen_sum[18] ? '1 : pen_sum[17:0];

    // A space on this word counts as the candidate break point already.
    is_space   = item.char_class == CLS_SPACE;
    sp_valid_e = is_space | space_valid_r;
    sp_after_e = is_space ? next_pos : space_after_r;
    sp_pen_e   = is_space ? pen_x_r : space_pen_r;

    over      = (pen_sat > {2'b00, cfg.max_width}) && (line_begin_r < byte_pos_r);
    use_space = sp_valid_e && (sp_after_e > line_begin_r);
    pen_rem   = (pen_sat >= sp_pen_e) ? pen_sat - sp_pen_e : '0;
  end

  always_comb begin
    lines_done_nxt  = lines_done_r;
    line_begin_nxt  = line_begin_r;
    space_valid_nxt = space_valid_r;
    space_after_nxt = space_after_r;
    space_pen_nxt   = space_pen_r;
    pen_x_nxt       = pen_x_r;
    byte_pos_nxt    = byte_pos_r;
    halted_nxt      = halted_r;
    brk             = 1'b0;
    res_vld         = 1'b0;
    res             = '0;

    if (step_en) begin
      unique case (item.char_class) inside
        CLS_END: begin
          res_vld         = 1'b1;
          res.is_final    = 1'b1;
          res.line_count  = lines_inc;
          lines_done_nxt  = '0;
          line_begin_nxt  = '0;
          space_valid_nxt = 1'b0;
          space_after_nxt = '0;
          space_pen_nxt   = '0;
          pen_x_nxt       = '0;
          byte_pos_nxt    = '0;
          halted_nxt      = 1'b0;
        end
        CLS_NEWLINE: begin
          if (!halted_r) begin
            if (at_limit) begin
              halted_nxt = 1'b1;
            end else begin
              brk             = 1'b1;
              lines_done_nxt  = lines_inc[7:0];
              line_begin_nxt  = next_pos;
              pen_x_nxt       = '0;
              space_valid_nxt = 1'b0;
              byte_pos_nxt    = next_pos;
            end
          end
        end
        CLS_OTHER, CLS_SPACE: begin
          if (!halted_r) begin
            space_valid_nxt = sp_valid_e;
            space_after_nxt = sp_after_e;
            space_pen_nxt   = sp_pen_e;
            pen_x_nxt       = pen_sat;
            if (over) begin
              if (at_limit) begin
                halted_nxt = 1'b1;
              end else begin
                brk            = 1'b1;
                lines_done_nxt = lines_inc[7:0];
                if (use_space) begin
                  line_begin_nxt = sp_after_e;
                  pen_x_nxt      = pen_rem;
                end else begin
                  line_begin_nxt = byte_pos_r;
                  pen_x_nxt      = '0;
                end
                space_valid_nxt = 1'b0;
                space_pen_nxt   = '0;
                byte_pos_nxt    = next_pos;
              end
            end else begin
              byte_pos_nxt = next_pos;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // The offset is shown as its low 16 bits, zero-extended for narrow offsets.
    begin_ext = {16'd0, line_begin_nxt};
    if (brk) begin
      res_vld          = 1'b1;
      res.line_index   = lines_done_nxt;
      res.break_offset = begin_ext[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_done_r  <= '0;
      line_begin_r  <= '0;
      space_valid_r <= 1'b0;
      space_after_r <= '0;
      space_pen_r   <= '0;
      pen_x_r       <= '0;
      byte_pos_r    <= '0;
      halted_r      <= 1'b0;
    end else begin
      lines_done_r  <= lines_done_nxt;
      line_begin_r  <= line_begin_nxt;
      space_valid_r <= space_valid_nxt;
      space_after_r <= space_after_nxt;
      space_pen_r   <= space_pen_nxt;
      pen_x_r       <= pen_x_nxt;
      byte_pos_r    <= byte_pos_nxt;
      halted_r      <= halted_nxt;
    end
  end

  `GLB_ASSERT_NEXT(a_end_clears, step_en && item.char_class == CLS_END, lines_done_r == 8'd0 && byte_pos_r == '0 && !halted_r)
  `GLB_ASSERT_IMPL(a_no_break_halted, res_vld && !res.is_final, !halted_r)
  `GLB_ASSERT_NEXT(a_halt_holds, step_en && halted_r && item.char_class != CLS_END, halted_r && $stable(lines_done_r))

endmodule

// ===== hw/rtl/greedy_line_breaker.sv =====
// ----------------------------------------------------------------------------
// Greedy line breaker
// Streams code points and emits a word for every line break and for end of text.
// ----------------------------------------------------------------------------
// Takes one code point word per clock while the receiver keeps up. A code
// point is held in the input register until the core steps on it, and the
// result then waits in the result register until it is taken. A newline, or a
// pen width above max_width, yields a break word with the new line's index and
// byte offset while the line count is below max_lines; an end-of-text word
// yields the line count and clears the line state. Words that cause no break
// produce nothing. The rate is one word per cycle while results are taken, set
// by the core's state update (pen adder, width and offset compares). A waiting
// result holds the word in the input register, so while the receiver stalls
// the block takes at most one more word and then drops in_ready until the
// result register is free. Configuration writes take effect on the next clock.

module greedy_line_breaker #(
  parameter int MAX_LINES   = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  glb_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output glb_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  glb_pkg::cfg_index_t                 cfg_index,
  input  logic [glb_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import glb_pkg::*;

  cfg_t      cfg_r;
  logic      in_vld_r;
  in_word_t  in_r;
  logic      out_vld_r, out_vld_nxt;
  out_word_t out_r;
  logic      advance;
  logic      res_vld;
  out_word_t res;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    out_vld_nxt = advance ? res_vld : (out_vld_r && !out_ready);
  end

  glb_core #(
    .MAX_LINES   (MAX_LINES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_r),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_width       <= MAX_WIDTH_RST;
      cfg_r.max_lines       <= MAX_LINES_RST;
      cfg_r.missing_advance <= MISSING_ADVANCE_RST;
      in_vld_r              <= 1'b0;
      out_vld_r             <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_WIDTH:       cfg_r.max_width       <= cfg_wdata;
          CFG_MAX_LINES:       cfg_r.max_lines       <= cfg_wdata[8:0];
          CFG_MISSING_ADVANCE: cfg_r.missing_advance <= cfg_wdata[11:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

endmodule
